/* hw/rtl/fpfa_pkg.sv */
// ----------------------------------------------------------------------------
// fpfa_pkg: shared constants for the fixed partition fit allocator
// Field widths and fit policy codes used by the top level and the selector.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int SIZE_W   = 16;
    localparam int BIDX_W   = 4;
    localparam int POLICY_W = 2;

    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [POLICY_W-1:0] policy_t;

    localparam policy_t POL_FIRST = 2'd0;
    localparam policy_t POL_BEST  = 2'd1;
    localparam policy_t POL_WORST = 2'd2;

endpackage

/* hw/rtl/fpfa_select.sv */
// ----------------------------------------------------------------------------
// fpfa_select: shared fit compare unit
// Decides whether the partition under test replaces the current candidate.
// ----------------------------------------------------------------------------
module fpfa_select
(
    input  fpfa_pkg::size_t   cand_size,
    input  fpfa_pkg::size_t   want_size,
    input  fpfa_pkg::size_t   best_size,
    input  logic              have_best,
    input  fpfa_pkg::policy_t policy,
    output logic              take
);

    logic fits;

    assign fits = (cand_size >= want_size);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!have_best)
            begin
                take = 1'b1;
            end
            else
            begin
                unique case (policy)
                    fpfa_pkg::POL_BEST:  take = (cand_size < best_size);
                    fpfa_pkg::POL_WORST: take = (cand_size > best_size);
                    // first fit and the unused code keep the lowest match
                    default:             take = 1'b0;
                endcase
            end
        end
    end

endmodule

/* hw/rtl/fixed_partition_fit_allocator_unit.sv */
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_unit: first/best/worst fit partition allocator
// Holds a table of partition sizes; a load transaction writes one entry and a
// request transaction scans the table and grants one fitting partition.
// ----------------------------------------------------------------------------
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------
//  input     | start / busy     | kind, block_index, block_size, request_size
//  config    | cfg_we           | cfg_wdata (fit policy)
//  result    | done (1 cycle)   | granted, granted_index
//
// A load transaction completes in the accepting cycle; busy stays low.
// A request transaction keeps busy high through the scan, drain and write-back
// states: one table read per cycle through the single memory read port feeding
// one shared compare unit, then a drain state for the last compare and a write-back state.
// The result strobe rises in the same cycle that busy drops.
// Reset clears the table through per-entry valid bits, so no clearing pass.
// The receiver cannot stall: done is asserted for exactly one cycle.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_unit
#(
    parameter int NUM_BLOCKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [3:0]  block_index,
    input  logic [15:0] block_size,
    input  logic [15:0] request_size,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    output logic        done,
    output logic        granted,
    output logic [3:0]  granted_index
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_WB    = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

    // Partition table storage; valid bits stand in for the reset clear.
    fpfa_pkg::size_t mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg, valid_next;

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   ctr_reg, ctr_next;
    fpfa_pkg::policy_t  policy_reg, policy_next;
    fpfa_pkg::size_t    want_reg, want_next;
    fpfa_pkg::size_t    best_size_reg, best_size_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               have_reg, have_next;

    // Read stage: registered data, its valid bit and its index.
    fpfa_pkg::size_t    rd_data_reg;
    logic               rd_valid_reg, rd_valid_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;

    logic               done_reg, done_next;
    logic               granted_reg, granted_next;
    logic [3:0]         gidx_reg, gidx_next;

    logic               accept;
    logic               load_hit;
    logic [8:0]         load_idx_ext;
    logic [8:0]         best_idx_ext;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    fpfa_pkg::size_t    wr_data;
    fpfa_pkg::size_t    cand_size;
    logic               take;

    assign accept       = start && !busy;
    assign load_idx_ext = {5'd0, block_index};
    assign load_hit     = accept && !kind && (load_idx_ext < 9'(NUM_BLOCKS));
    assign best_idx_ext = 9'(best_idx_reg);

    // Entry that was never loaded reads as zero and so never fits.
    assign cand_size = rd_valid_reg ? rd_data_reg : '0;

    fpfa_select u_select
    (
        .cand_size (cand_size),
        .want_size (want_reg),
        .best_size (best_size_reg),
        .have_best (have_reg),
        .policy    (policy_reg),
        .take      (take)
    );

    // Single write port: a load when idle, the grant clear at write-back.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = load_idx_ext[IDX_W-1:0];
        wr_data = block_size;
        if (load_hit)
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == ST_WB) && have_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = best_idx_reg;
            wr_data = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctr_next       = ctr_reg;
        policy_next    = policy_reg;
        want_next      = want_reg;
        best_size_next = best_size_reg;
        best_idx_next  = best_idx_reg;
        have_next      = have_reg;
        rd_valid_next  = valid_reg[ctr_reg];
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = ctr_reg;
        done_next      = 1'b0;
        granted_next   = granted_reg;
        gidx_next      = gidx_reg;
        valid_next     = valid_reg;

        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end

        if (cfg_we)
        begin
            policy_next = cfg_wdata;
        end

        // Fold in the entry read last cycle.
        if (cmp_vld_reg && take)
        begin
            best_size_next = cand_size;
            best_idx_next  = cmp_idx_reg;
            have_next      = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind)
                begin
                    // A zero request is treated as one unit.
                    want_next  = (request_size == '0) ? 16'd1 : request_size;
                    ctr_next   = '0;
                    have_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = 1'b1;
                if (ctr_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                done_next    = 1'b1;
                granted_next = have_reg;
                gidx_next    = have_reg ? best_idx_ext[3:0] : 4'd0;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ctr_reg      <= '0;
            policy_reg   <= fpfa_pkg::POL_FIRST;
            have_reg     <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            policy_reg   <= policy_next;
            have_reg     <= have_next;
            cmp_vld_reg  <= cmp_vld_next;
            rd_valid_reg <= rd_valid_next;
            done_reg     <= done_next;
            valid_reg    <= valid_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        want_reg      <= want_next;
        best_size_reg <= best_size_next;
        best_idx_reg  <= best_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        granted_reg   <= granted_next;
        gidx_reg      <= gidx_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[ctr_reg];
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign granted       = granted_reg;
    assign granted_index = gidx_reg;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fixed_partition_fit_allocator_unit
// Loads partition sizes and issues allocation requests under every fit policy.
// A directed table of corner cases comes first, then about 1500 random
// transactions. Each strobe is compared with the grant typed into its row, if
// any, else with a reference table of partition sizes kept by the bench.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BLOCKS    = 16;
    // A request holds busy through scan, drain and write-back and strobes done as
    // busy drops; leave a margin on top of that before touching the policy.
    localparam int DRAIN_CYCLES  = NUM_BLOCKS + 8;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int SHOWN_ERRORS  = 10;
    localparam int LIMIT_NS      = 2_000_000;

    localparam logic    KIND_LOAD = 1'b0;
    localparam logic    KIND_ASK  = 1'b1;
    // The fourth policy code is unused and has to behave as first fit.
    localparam fpfa_pkg::policy_t POL_SPARE = 2'd3;

    typedef enum logic [1:0] {ROW_LOAD, ROW_ASK, ROW_POLICY} row_op_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } grant_t;

    // One line of the directed stimulus. For ROW_ASK val is the request size,
    // for ROW_LOAD it is the partition size, for ROW_POLICY the policy code.
    // Rows with typed set carry their grant written out by hand.
    typedef struct {
        row_op_t         op;
        logic [3:0]      idx;
        fpfa_pkg::size_t val;
        bit              typed;
        logic            exp_hit;
        logic [3:0]      exp_idx;
    } dir_row_t;

    localparam int N_DIR = 29;

    dir_row_t dir_rows [N_DIR] = '{
        // Table is empty after reset, policy is first fit: nothing can match.
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'hFFFF,            1'b1, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd0,  16'hFFFF,            1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd15, 16'd1,               1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd7,  16'd100,             1'b0, 1'b0, 4'd0},
        // A zero-size request counts as size one.
        '{ROW_ASK,    4'd0,  16'd0,               1'b1, 1'b1, 4'd0},
        '{ROW_ASK,    4'd0,  16'hFFFF,            1'b1, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b1, 4'd7},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b1, 4'd15},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b0, 4'd0},
        // Best fit: equal sizes at 9 and 12 resolve to the lower index.
        '{ROW_POLICY, 4'd0,  fpfa_pkg::POL_BEST,  1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd3,  16'd50,              1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd9,  16'd20,              1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd12, 16'd20,              1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd5,  16'hFFFF,            1'b0, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'd20,              1'b1, 1'b1, 4'd9},
        '{ROW_ASK,    4'd0,  16'd21,              1'b1, 1'b1, 4'd3},
        // Worst fit drains the largest entries first.
        '{ROW_POLICY, 4'd0,  fpfa_pkg::POL_WORST, 1'b0, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b1, 4'd5},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b1, 4'd12},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b0, 4'd0},
        // Unused policy code falls back to first fit.
        '{ROW_POLICY, 4'd0,  POL_SPARE,           1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd2,  16'd8,               1'b0, 1'b0, 4'd0},
        '{ROW_LOAD,   4'd1,  16'hFFFF,            1'b0, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'd8,               1'b1, 1'b1, 4'd1},
        '{ROW_LOAD,   4'd0,  16'd0,               1'b0, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'd1,               1'b1, 1'b1, 4'd2},
        '{ROW_LOAD,   4'd4,  16'd300,             1'b0, 1'b0, 4'd0},
        '{ROW_ASK,    4'd0,  16'd200,             1'b0, 1'b0, 4'd0}
    };

    // ------------------------------------------------------------------------
    // Block inputs, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        start         = 1'b0;
    logic        busy;
    logic        kind          = 1'b0;
    logic [3:0]  block_index   = 4'd0;
    logic [15:0] block_size    = 16'd0;
    logic [15:0] request_size  = 16'd0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_wdata     = 2'd0;
    logic        done;
    logic        granted;
    logic [3:0]  granted_index;

    fixed_partition_fit_allocator_unit #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .block_index   (block_index),
        .block_size    (block_size),
        .request_size  (request_size),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .granted       (granted),
        .granted_index (granted_index)
    );

    // ------------------------------------------------------------------------
    // Reference state: partition sizes and the active policy
    // ------------------------------------------------------------------------
    fpfa_pkg::size_t   part_size [NUM_BLOCKS];
    fpfa_pkg::policy_t cur_policy;

    // Grants owed by the block, oldest first.
    grant_t  grant_queue [$];

    bit      gaps_on       = 1'b1;
    int      mismatches    = 0;
    int      n_loads       = 0;
    int      n_asks        = 0;
    int      n_results     = 0;
    int      n_grants      = 0;
    int      n_cfg_writes  = 0;
    logic [3:0] policies_seen = 4'b0000;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs or never strobes a pending grant.
    initial
    begin
        #(LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Search the reference table under the current policy and claim the hit.
    // Ties keep the lower index since only a strictly better size replaces it.
    function automatic grant_t pick_fit(input fpfa_pkg::size_t asked);
        grant_t          g;
        fpfa_pkg::size_t want;
        int              chosen;
        int              i;
        want   = (asked == '0) ? fpfa_pkg::size_t'(1) : asked;
        chosen = -1;
        for (i = 0; i < NUM_BLOCKS; i++)
        begin
            if (part_size[i] >= want)
            begin
                if (chosen < 0)
                    chosen = i;
                else if (cur_policy == fpfa_pkg::POL_BEST &&
                         part_size[i] < part_size[chosen])
                    chosen = i;
                else if (cur_policy == fpfa_pkg::POL_WORST &&
                         part_size[i] > part_size[chosen])
                    chosen = i;
            end
        end
        if (chosen < 0)
        begin
            g.hit = 1'b0;
            g.idx = 4'd0;
        end
        else
        begin
            part_size[chosen] = '0;
            g.hit = 1'b1;
            g.idx = chosen[3:0];
        end
        return g;
    endfunction

    // Sizes lean toward a narrow range so that best and worst fit see ties,
    // with the corner values and the full range mixed in.
    function automatic fpfa_pkg::size_t pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return fpfa_pkg::size_t'($urandom_range(32, 1));
        if (r < 60)
        begin
            case ($urandom_range(3))
                0: return 16'd0;
                1: return 16'd1;
                2: return 16'hFFFF;
                default: return 16'hFFFE;
            endcase
        end
        return fpfa_pkg::size_t'($urandom_range(16'hFFFF, 0));
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Present one transaction, hold it until the block takes it, then update
    // the reference table. Start stays high after acceptance so that
    // back-to-back transactions need no second assignment in the same step.
    task automatic issue(input logic k, input logic [3:0] bi,
                         input fpfa_pkg::size_t bs, input fpfa_pkg::size_t rs,
                         input bit typed, input grant_t typed_g);
        grant_t g;
        if (gaps_on && $urandom_range(99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(24, 1)) @(posedge clk);
        end
        start        <= 1'b1;
        kind         <= k;
        block_index  <= bi;
        block_size   <= bs;
        request_size <= rs;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (k == KIND_LOAD)
        begin
            part_size[bi] = bs;
            n_loads++;
        end
        else
        begin
            g = pick_fit(rs);
            grant_queue.push_back(typed ? typed_g : g);
            n_asks++;
        end
    endtask

    // Drop start, wait out every owed grant, then let the last load settle.
    task automatic settle();
        start <= 1'b0;
        while (grant_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Change the fit policy only while the block is idle.
    task automatic write_policy(input fpfa_pkg::policy_t p);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_policy = p;
        policies_seen[p] = 1'b1;
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every done strobe must match the oldest owed grant
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        grant_t owed;
        if (rst_n && done === 1'b1)
        begin
            n_results++;
            if (granted === 1'b1)
                n_grants++;
            if (grant_queue.size() == 0)
                note_mismatch($sformatf("unexpected grant strobe granted=%0b index=%0d",
                                        granted, granted_index));
            else
            begin
                owed = grant_queue.pop_front();
                if (granted !== owed.hit || granted_index !== owed.idx)
                    note_mismatch($sformatf(
                        "expected granted=%0b index=%0d, got granted=%0b index=%0d",
                        owed.hit, owed.idx, granted, granted_index));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        fpfa_pkg::policy_t phase_pol [4];
        fpfa_pkg::policy_t pol;
        grant_t            tg;
        int                i;
        int                phase;
        int                n;

        phase_pol = '{fpfa_pkg::POL_BEST, fpfa_pkg::POL_WORST,
                      fpfa_pkg::POL_FIRST, POL_SPARE};
        for (i = 0; i < NUM_BLOCKS; i++)
            part_size[i] = '0;
        cur_policy = fpfa_pkg::POL_FIRST;

        // Hold reset, then release it before the directed table starts.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: starts on the reset policy before any write.
        for (i = 0; i < N_DIR; i++)
        begin
            tg.hit = dir_rows[i].exp_hit;
            tg.idx = dir_rows[i].exp_idx;
            case (dir_rows[i].op)
                ROW_POLICY:
                    write_policy(fpfa_pkg::policy_t'(dir_rows[i].val[1:0]));
                ROW_LOAD:
                    issue(KIND_LOAD, dir_rows[i].idx, dir_rows[i].val,
                          fpfa_pkg::size_t'($urandom_range(16'hFFFF, 0)), 1'b0, tg);
                default:
                    issue(KIND_ASK, 4'($urandom_range(15)),
                          fpfa_pkg::size_t'($urandom_range(16'hFFFF, 0)),
                          dir_rows[i].val, dir_rows[i].typed, tg);
            endcase
        end

        // Random phases, one policy each; phase two runs with no sender gaps.
        tg = '0;
        for (phase = 0; phase < PHASES; phase++)
        begin
            pol = (phase < 4) ? phase_pol[phase]
                              : fpfa_pkg::policy_t'($urandom_range(3));
            write_policy(pol);
            gaps_on = (phase != 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 55)
                    issue(KIND_LOAD, 4'($urandom_range(15)), pick_size(),
                          fpfa_pkg::size_t'($urandom_range(16'hFFFF, 0)), 1'b0, tg);
                else
                    issue(KIND_ASK, 4'($urandom_range(15)),
                          fpfa_pkg::size_t'($urandom_range(16'hFFFF, 0)),
                          pick_size(), 1'b0, tg);
                // Now and then pause until every owed grant has come back.
                if ($urandom_range(99) == 0)
                    settle();
            end
        end

        settle();

        $display("Covered %0d loads and %0d requests, %0d strobes seen, %0d granted",
                 n_loads, n_asks, n_results, n_grants);
        $display("Policy written %0d times, codes used mask %b, %0d mismatches",
                 n_cfg_writes, policies_seen, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* fixed_partition_fit_allocator_unit.f */
hw/rtl/fpfa_pkg.sv
hw/rtl/fpfa_select.sv
hw/rtl/fixed_partition_fit_allocator_unit.sv
verif/testbench.sv
